@@ rtl/r2q_pkg.sv @@
// Package for the rotator-to-quaternion block: CORDIC constants and widths.
package r2q_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;
    localparam int ZW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
    } sincos_t;

    // Arctangent of 2^-i, in units of 2^32 per full turn.
    function automatic logic signed [ZW-1:0] atan_turn32(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            r = '0;
            case (i)
                5'd0:  r = 34'sh20000000;
                5'd1:  r = 34'sh12E4051E;
                5'd2:  r = 34'sh09FB385B;
                5'd3:  r = 34'sh051111D4;
                5'd4:  r = 34'sh028B0D43;
                5'd5:  r = 34'sh0145D7E1;
                5'd6:  r = 34'sh00A2F61E;
                5'd7:  r = 34'sh00517C55;
                5'd8:  r = 34'sh0028BE53;
                5'd9:  r = 34'sh00145F2F;
                5'd10: r = 34'sh000A2F98;
                5'd11: r = 34'sh000517CC;
                5'd12: r = 34'sh00028BE6;
                5'd13: r = 34'sh000145F3;
                5'd14: r = 34'sh0000A2FA;
                5'd15: r = 34'sh0000517D;
                5'd16: r = 34'sh000028BE;
                5'd17: r = 34'sh0000145F;
                5'd18: r = 34'sh00000A30;
                5'd19: r = 34'sh00000518;
                5'd20: r = 34'sh0000028C;
                5'd21: r = 34'sh00000146;
                5'd22: r = 34'sh000000A3;
                5'd23: r = 34'sh00000051;
                5'd24: r = 34'sh00000029;
                5'd25: r = 34'sh00000014;
                5'd26: r = 34'sh0000000A;
                5'd27: r = 34'sh00000005;
                5'd28: r = 34'sh00000003;
                5'd29: r = 34'sh00000001;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/r2q_cordic.sv @@
// Pipelined CORDIC lane: half-angle sine and cosine in Q4.30 (34-bit signed), one stage per step.
module r2q_cordic
    import r2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output sincos_t                      result
);

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];

    // Load the angle scaled to 2^32 units per turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(angle) <<< (31 - ANGLE_BITS);
        end
    end

    // One rotation per stage, advanced together with the pipe
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_turn32(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_turn32(5'(i));
                end
            end
        end
    end

    assign result.c = x_reg[CORDIC_STEPS];
    assign result.s = y_reg[CORDIC_STEPS];

endmodule

@@ rtl/r2q_merge.sv @@
// Merge stage: triple products of the lane outputs, rounding and saturation.
module r2q_merge
    import r2q_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  logic                        clk,
    input  logic                        en,
    input  sincos_t                     p,
    input  sincos_t                     y,
    input  sincos_t                     r,
    output logic signed [FRAC_BITS:0]   qx,
    output logic signed [FRAC_BITS:0]   qy,
    output logic signed [FRAC_BITS:0]   qz,
    output logic signed [FRAC_BITS:0]   qw
);

    localparam int PW = 2 * CW;
    localparam int SW = PW + 2;
    localparam int RS = 60 - FRAC_BITS;

    // Q60 products of pairs, then rounded to Q30
    logic signed [PW-1:0] ab_reg [8];
    logic signed [CW-1:0] c1_reg [8];
    logic signed [CW-1:0] c2_reg [8];
    logic signed [CW-1:0] ab30_reg [8];
    logic signed [PW-1:0] t_reg [8];
    logic signed [SW-1:0] sum_reg [4];
    logic signed [FRAC_BITS:0] q_reg [4];

    // Products in the order: x+, x-, y-, y-, z+, z-, w+, w+
    logic signed [CW-1:0] fa [8];
    logic signed [CW-1:0] fb [8];
    logic signed [CW-1:0] fc [8];

    always_comb
    begin
        fa[0] = r.c; fb[0] = p.s; fc[0] = y.s;
        fa[1] = r.s; fb[1] = p.c; fc[1] = y.c;
        fa[2] = r.c; fb[2] = p.s; fc[2] = y.c;
        fa[3] = r.s; fb[3] = p.c; fc[3] = y.s;
        fa[4] = r.c; fb[4] = p.c; fc[4] = y.s;
        fa[5] = r.s; fb[5] = p.s; fc[5] = y.c;
        fa[6] = r.c; fb[6] = p.c; fc[6] = y.c;
        fa[7] = r.s; fb[7] = p.s; fc[7] = y.s;
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_prod
        logic signed [PW-1:0] rnd;
        assign rnd = (ab_reg[k] + (PW'(1) <<< 29)) >>> 30;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ab_reg[k]   <= fa[k] * fb[k];
                c1_reg[k]   <= fc[k];
                ab30_reg[k] <= rnd[CW-1:0];
                c2_reg[k]   <= c1_reg[k];
                t_reg[k]    <= ab30_reg[k] * c2_reg[k];
            end
        end
    end

    // Combine pairs into components
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= SW'(t_reg[0]) - SW'(t_reg[1]);
            sum_reg[1] <= -SW'(t_reg[2]) - SW'(t_reg[3]);
            sum_reg[2] <= SW'(t_reg[4]) - SW'(t_reg[5]);
            sum_reg[3] <= SW'(t_reg[6]) + SW'(t_reg[7]);
        end
    end

    // Round to output precision and saturate
    for (genvar k = 0; k < 4; k++)
    begin : g_out
        logic signed [SW-1:0] q;
        assign q = (sum_reg[k] + (SW'(1) <<< (RS - 1))) >>> RS;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (q > SW'((64'sd1 <<< FRAC_BITS) - 1))
                    q_reg[k] <= {1'b0, {FRAC_BITS{1'b1}}};
                else if (q < -SW'(64'sd1 <<< FRAC_BITS))
                    q_reg[k] <= {1'b1, {FRAC_BITS{1'b0}}};
                else
                    q_reg[k] <= q[FRAC_BITS:0];
            end
        end
    end

    assign qx = q_reg[0];
    assign qy = q_reg[1];
    assign qz = q_reg[2];
    assign qw = q_reg[3];

endmodule

@@ rtl/rotator_to_quaternion.sv @@
// Top level: three CORDIC lanes and a merge stage, rotator to unit quaternion.
//   channel   dir  fields (low bit first)
//   s_axis    in   tdata: pitch_angle, yaw_angle, roll_angle
//   m_axis    out  tdata: quat_x, quat_y, quat_z, quat_w
// One word accepted per cycle while the pipe is not stalled; the pipe holds CORDIC_STEPS + 1
// lane stages plus 5 merge stages, set by the 30-step CORDIC pipeline.
// The whole pipe advances when the output register is empty or being taken,
// so s_axis_tready follows m_axis_tready or an empty output slot.
// Reset clears only the valid bits of the pipe.
module rotator_to_quaternion
    import r2q_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 15
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pitch_angle, yaw_angle, roll_angle
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int LAT = CORDIC_STEPS + 1 + 5;
    localparam int QW  = FRAC_BITS + 1;
    localparam int OW  = ((4*QW+7)/8)*8;

    logic en;
    logic [LAT-1:0] vld_reg;
    sincos_t sc_p, sc_y, sc_r;
    logic signed [QW-1:0] qx, qy, qz, qw;

    // Advance when the last stage is empty or taken
    assign en = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    r2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_lane_p (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[ANGLE_BITS-1:0]), .result(sc_p));
    r2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_lane_y (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .result(sc_y));
    r2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_lane_r (
        .clk(clk), .en(en),
        .angle(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .result(sc_r));

    r2q_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk(clk), .en(en), .p(sc_p), .y(sc_y), .r(sc_r),
        .qx(qx), .qy(qy), .qz(qz), .qw(qw));

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = OW'({qw, qz, qy, qx});

    // A stalled output holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // Input is accepted whenever output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe stalled with empty output");

    // Pipe does not shift while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved under stall");

endmodule
